### src/mse_pkg.sv
// Package for the MIPS64 special integer execute block.
// Holds operation codes, exception codes, payload structs and the front-to-back record.
// No dependencies.
package mse_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueueIdxW  = 1;

    typedef enum logic [5:0] {
        OP_SLL = 6'd0, OP_SRL = 6'd1, OP_SRA = 6'd2, OP_SLLV = 6'd3, OP_SRLV = 6'd4,
        OP_SRAV = 6'd5, OP_DSLL = 6'd6, OP_DSRL = 6'd7, OP_DSRA = 6'd8, OP_DSLLV = 6'd9,
        OP_DSRLV = 6'd10, OP_DSRAV = 6'd11, OP_DSLL32 = 6'd12, OP_DSRL32 = 6'd13,
        OP_DSRA32 = 6'd14, OP_ADD = 6'd15, OP_ADDU = 6'd16, OP_SUB = 6'd17,
        OP_SUBU = 6'd18, OP_DADD = 6'd19, OP_DADDU = 6'd20, OP_DSUB = 6'd21,
        OP_DSUBU = 6'd22, OP_MULT = 6'd23, OP_MULTU = 6'd24, OP_DIV = 6'd25,
        OP_DIVU = 6'd26, OP_DMULT = 6'd27, OP_DMULTU = 6'd28, OP_DDIV = 6'd29,
        OP_DDIVU = 6'd30, OP_AND = 6'd31, OP_OR = 6'd32, OP_XOR = 6'd33, OP_NOR = 6'd34,
        OP_TGE = 6'd35, OP_TGEU = 6'd36, OP_TLT = 6'd37, OP_TLTU = 6'd38, OP_TEQ = 6'd39,
        OP_TNE = 6'd40, OP_TGEI = 6'd41, OP_TGEIU = 6'd42, OP_TLTI = 6'd43,
        OP_TLTIU = 6'd44, OP_TEQI = 6'd45, OP_TNEI = 6'd46, OP_SLT = 6'd47,
        OP_SLTU = 6'd48, OP_SYSCALL = 6'd49, OP_BREAK = 6'd50, OP_SYNC = 6'd51,
        OP_MFHI = 6'd52, OP_MTHI = 6'd53, OP_MFLO = 6'd54, OP_MTLO = 6'd55
    } op_t;

    localparam logic [2:0] EXC_NONE     = 3'd0;
    localparam logic [2:0] EXC_OVERFLOW = 3'd1;
    localparam logic [2:0] EXC_TRAP     = 3'd2;
    localparam logic [2:0] EXC_SYSCALL  = 3'd3;
    localparam logic [2:0] EXC_BREAK    = 3'd4;

    typedef enum logic [2:0] {
        CLS_SIMPLE = 3'b001,
        CLS_MUL    = 3'b010,
        CLS_DIV    = 3'b100
    } cls_t;

    typedef struct packed {
        logic [5:0]         req_type;
        logic [63:0]        rs_value;
        logic [63:0]        rt_value;
        logic [4:0]         shift_amount;
        logic signed [15:0] immediate;
    } req_t;

    typedef struct packed {
        logic        dest_write;
        logic [63:0] dest_value;
        logic [2:0]  exception_code;
    } rsp_t;

    // Decoded word passed from the front end to the back end.
    typedef struct packed {
        cls_t        cls;
        logic [5:0]  op;
        logic [63:0] rs;
        logic [63:0] rt;
        rsp_t        rsp;
    } work_t;

    function automatic logic [63:0] sext32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

### src/mse_front.sv
// Front end: accepts request words, computes simple operations and classifies the rest.
// Depends on mse_pkg.
module mse_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mse_pkg::req_t       s_data,
    output logic                f_valid,
    input  logic                f_ready,
    output mse_pkg::work_t      f_data
);
    mse_pkg::work_t w_reg, w_next;
    logic           v_reg;
    logic [63:0]    rs, rt, imm, val, shl, shr, sra;
    logic [5:0]     shamt;
    logic [31:0]    r32;
    logic [63:0]    r64;
    logic           wr, trap, ovf;
    logic [2:0]     exc;
    mse_pkg::cls_t  cls;

    assign s_ready = !v_reg || f_ready;
    assign f_valid = v_reg;
    assign f_data  = w_reg;

    always_comb begin
        rs    = s_data.rs_value;
        rt    = s_data.rt_value;
        imm   = {{48{s_data.immediate[15]}}, s_data.immediate};
        wr    = 1'b0;
        trap  = 1'b0;
        ovf   = 1'b0;
        val   = '0;
        exc   = mse_pkg::EXC_NONE;
        cls   = mse_pkg::CLS_SIMPLE;
        r32   = '0;
        r64   = '0;
        case (s_data.req_type)
            mse_pkg::OP_SLL, mse_pkg::OP_SRL, mse_pkg::OP_SRA, mse_pkg::OP_DSLL,
            mse_pkg::OP_DSRL, mse_pkg::OP_DSRA: shamt = {1'b0, s_data.shift_amount};
            mse_pkg::OP_SLLV, mse_pkg::OP_SRLV, mse_pkg::OP_SRAV: shamt = {1'b0, rs[4:0]};
            mse_pkg::OP_DSLLV, mse_pkg::OP_DSRLV, mse_pkg::OP_DSRAV: shamt = rs[5:0];
            default: shamt = {1'b1, s_data.shift_amount};
        endcase
        shl = rt << shamt;
        shr = rt >> shamt;
        sra = $signed(rt) >>> shamt;
        case (s_data.req_type)
            mse_pkg::OP_SLL, mse_pkg::OP_SLLV: begin
                val = mse_pkg::sext32(shl[31:0]); wr = 1'b1;
            end
            mse_pkg::OP_SRL, mse_pkg::OP_SRLV: begin
                r64 = {32'd0, rt[31:0]} >> shamt;
                val = mse_pkg::sext32(r64[31:0]); wr = 1'b1;
            end
            mse_pkg::OP_SRA, mse_pkg::OP_SRAV: begin
                val = mse_pkg::sext32(sra[31:0]); wr = 1'b1;
            end
            mse_pkg::OP_DSLL, mse_pkg::OP_DSLLV, mse_pkg::OP_DSLL32: begin
                val = shl; wr = 1'b1;
            end
            mse_pkg::OP_DSRL, mse_pkg::OP_DSRLV, mse_pkg::OP_DSRL32: begin
                val = shr; wr = 1'b1;
            end
            mse_pkg::OP_DSRA, mse_pkg::OP_DSRAV, mse_pkg::OP_DSRA32: begin
                val = sra; wr = 1'b1;
            end
            mse_pkg::OP_ADD, mse_pkg::OP_ADDU: begin
                r32 = rs[31:0] + rt[31:0];
                ovf = (s_data.req_type == mse_pkg::OP_ADD) &&
                      ((rs[31] ^ r32[31]) & (rt[31] ^ r32[31]));
                val = mse_pkg::sext32(r32); wr = 1'b1;
            end
            mse_pkg::OP_SUB, mse_pkg::OP_SUBU: begin
                r32 = rs[31:0] - rt[31:0];
                ovf = (s_data.req_type == mse_pkg::OP_SUB) &&
                      ((rs[31] ^ rt[31]) & (rs[31] ^ r32[31]));
                val = mse_pkg::sext32(r32); wr = 1'b1;
            end
            mse_pkg::OP_DADD, mse_pkg::OP_DADDU: begin
                r64 = rs + rt;
                ovf = (s_data.req_type == mse_pkg::OP_DADD) &&
                      ((rs[63] ^ r64[63]) & (rt[63] ^ r64[63]));
                val = r64; wr = 1'b1;
            end
            mse_pkg::OP_DSUB, mse_pkg::OP_DSUBU: begin
                r64 = rs - rt;
                ovf = (s_data.req_type == mse_pkg::OP_DSUB) &&
                      ((rs[63] ^ rt[63]) & (rs[63] ^ r64[63]));
                val = r64; wr = 1'b1;
            end
            mse_pkg::OP_MULT, mse_pkg::OP_MULTU, mse_pkg::OP_DMULT,
            mse_pkg::OP_DMULTU: cls = mse_pkg::CLS_MUL;
            mse_pkg::OP_DIV, mse_pkg::OP_DIVU, mse_pkg::OP_DDIV,
            mse_pkg::OP_DDIVU: cls = mse_pkg::CLS_DIV;
            mse_pkg::OP_AND: begin val = rs & rt; wr = 1'b1; end
            mse_pkg::OP_OR:  begin val = rs | rt; wr = 1'b1; end
            mse_pkg::OP_XOR: begin val = rs ^ rt; wr = 1'b1; end
            mse_pkg::OP_NOR: begin val = ~(rs | rt); wr = 1'b1; end
            mse_pkg::OP_TGE:   trap = $signed(rs) >= $signed(rt);
            mse_pkg::OP_TGEU:  trap = rs >= rt;
            mse_pkg::OP_TLT:   trap = $signed(rs) < $signed(rt);
            mse_pkg::OP_TLTU:  trap = rs < rt;
            mse_pkg::OP_TEQ:   trap = rs == rt;
            mse_pkg::OP_TNE:   trap = rs != rt;
            mse_pkg::OP_TGEI:  trap = $signed(rs) >= $signed(imm);
            mse_pkg::OP_TGEIU: trap = rs >= imm;
            mse_pkg::OP_TLTI:  trap = $signed(rs) < $signed(imm);
            mse_pkg::OP_TLTIU: trap = rs < imm;
            mse_pkg::OP_TEQI:  trap = rs == imm;
            mse_pkg::OP_TNEI:  trap = rs != imm;
            mse_pkg::OP_SLT: begin
                val = {63'd0, $signed(rs) < $signed(rt)}; wr = 1'b1;
            end
            mse_pkg::OP_SLTU: begin val = {63'd0, rs < rt}; wr = 1'b1; end
            mse_pkg::OP_SYSCALL: exc = mse_pkg::EXC_SYSCALL;
            mse_pkg::OP_BREAK:   exc = mse_pkg::EXC_BREAK;
            mse_pkg::OP_MFHI, mse_pkg::OP_MTHI, mse_pkg::OP_MFLO,
            mse_pkg::OP_MTLO: cls = mse_pkg::CLS_MUL;
            default: ;
        endcase
        if (ovf) begin
            wr  = 1'b0;
            exc = mse_pkg::EXC_OVERFLOW;
        end
        if (trap) exc = mse_pkg::EXC_TRAP;
        w_next.cls                = cls;
        w_next.op                 = s_data.req_type;
        w_next.rs                 = rs;
        w_next.rt                 = rt;
        w_next.rsp.dest_write     = wr;
        w_next.rsp.dest_value     = wr ? val : 64'd0;
        w_next.rsp.exception_code = exc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (s_ready) begin
            v_reg <= s_valid;
        end
        if (s_valid && s_ready) w_reg <= w_next;
    end
endmodule

### src/mse_queue.sv
// Two-entry queue between front and back ends.
// Depends on mse_pkg.
module mse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           i_valid,
    output logic           i_ready,
    input  mse_pkg::work_t i_data,
    output logic           o_valid,
    input  logic           o_ready,
    output mse_pkg::work_t o_data
);
    mse_pkg::work_t                     mem_reg [mse_pkg::QueueDepth];
    logic [mse_pkg::QueueIdxW-1:0]      wp_reg, rp_reg;
    logic [mse_pkg::QueueIdxW:0]        cnt_reg;
    logic                               push, pop;

    assign i_ready = cnt_reg != (mse_pkg::QueueIdxW+1)'(mse_pkg::QueueDepth);
    assign o_valid = cnt_reg != '0;
    assign o_data  = mem_reg[rp_reg];
    assign push    = i_valid && i_ready;
    assign pop     = o_valid && o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{mse_pkg::QueueIdxW{1'b0}}, push}
                               - {{mse_pkg::QueueIdxW{1'b0}}, pop};
        end
        if (push) mem_reg[wp_reg] <= i_data;
    end
endmodule

### src/mse_back.sv
// Back end: multiply, divide and HI/LO access, plus the output register.
// Depends on mse_pkg.
module mse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  mse_pkg::work_t q_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mse_pkg::rsp_t  m_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIX  = 4'b1000
    } state_t;

    state_t        state_reg;
    logic [63:0]   hi_reg, lo_reg;
    logic [63:0]   a_reg, b_reg;
    logic [5:0]    op_reg;
    logic [1:0]    step_reg;
    logic [127:0]  acc_reg;
    logic [63:0]   rem_reg, quo_reg, dvd_reg;
    logic [6:0]    cnt_reg;
    logic          nq_reg, nr_reg;
    logic          ov_reg;
    mse_pkg::rsp_t out_reg;
    logic          out_free;
    logic [63:0]   pp, mb;
    logic [31:0]   ma;
    logic [65:0]   trial;
    logic [64:0]   rem_sh;
    logic          is64, sgn;
    logic [63:0]   da, db, qf, rf;
    mse_pkg::rsp_t rsp_in;
    logic          mul_op, div_op, done, ov_next;

    assign out_free = !ov_reg || m_ready;
    assign m_valid  = ov_reg;
    assign m_data   = out_reg;
    assign q_ready  = state_reg == ST_IDLE && out_free;

    always_comb begin
        ma = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
        mb = step_reg[1] ? {32'd0, b_reg[63:32]} : {32'd0, b_reg[31:0]};
        pp = {32'd0, ma} * mb;
        rem_sh = {rem_reg, dvd_reg[63]};
        trial  = {1'b0, rem_sh} - {2'b0, b_reg};
        is64 = q_data.op == mse_pkg::OP_DDIV || q_data.op == mse_pkg::OP_DDIVU;
        sgn  = q_data.op == mse_pkg::OP_DIV || q_data.op == mse_pkg::OP_DDIV;
        if (is64) begin
            da = q_data.rs;
            db = q_data.rt;
        end else if (sgn) begin
            da = mse_pkg::sext32(q_data.rs[31:0]);
            db = mse_pkg::sext32(q_data.rt[31:0]);
        end else begin
            da = {32'd0, q_data.rs[31:0]};
            db = {32'd0, q_data.rt[31:0]};
        end
        qf = nq_reg ? -quo_reg : quo_reg;
        rf = nr_reg ? -rem_reg : rem_reg;
        rsp_in = q_data.rsp;
        if (q_data.op == mse_pkg::OP_MFHI) begin
            rsp_in.dest_write = 1'b1;
            rsp_in.dest_value = hi_reg;
        end else if (q_data.op == mse_pkg::OP_MFLO) begin
            rsp_in.dest_write = 1'b1;
            rsp_in.dest_value = lo_reg;
        end
        mul_op = q_data.op == mse_pkg::OP_MULT || q_data.op == mse_pkg::OP_MULTU ||
                 q_data.op == mse_pkg::OP_DMULT || q_data.op == mse_pkg::OP_DMULTU;
        div_op = q_data.cls == mse_pkg::CLS_DIV;
        done = (state_reg == ST_IDLE && q_valid && q_ready && !mul_op &&
                !(div_op && db != 64'd0)) || (state_reg == ST_FIX && out_free);
        ov_next = done || (ov_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end else begin
            ov_reg <= ov_next;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_ready) begin
                        out_reg <= rsp_in;
                        op_reg  <= q_data.op;
                        case (q_data.op)
                            mse_pkg::OP_MTHI: hi_reg <= q_data.rs;
                            mse_pkg::OP_MTLO: lo_reg <= q_data.rs;
                            mse_pkg::OP_MULT, mse_pkg::OP_MULTU: begin
                                a_reg <= q_data.op == mse_pkg::OP_MULT
                                    ? mse_pkg::sext32(q_data.rs[31:0])
                                    : {32'd0, q_data.rs[31:0]};
                                b_reg <= q_data.op == mse_pkg::OP_MULT
                                    ? mse_pkg::sext32(q_data.rt[31:0])
                                    : {32'd0, q_data.rt[31:0]};
                                acc_reg   <= '0;
                                step_reg  <= '0;
                                state_reg <= ST_MUL;
                            end
                            mse_pkg::OP_DMULT, mse_pkg::OP_DMULTU: begin
                                a_reg     <= q_data.rs;
                                b_reg     <= q_data.rt;
                                acc_reg   <= '0;
                                step_reg  <= '0;
                                state_reg <= ST_MUL;
                            end
                            mse_pkg::OP_DIV, mse_pkg::OP_DIVU, mse_pkg::OP_DDIV,
                            mse_pkg::OP_DDIVU: begin
                                if (db == 64'd0) begin
                                    lo_reg <= (sgn && da[63]) ? 64'd1 : '1;
                                    hi_reg <= (sgn && !is64) ? da : q_data.rs;
                                end else begin
                                    nq_reg  <= sgn && (da[63] ^ db[63]);
                                    nr_reg  <= sgn && da[63];
                                    dvd_reg <= (sgn && da[63]) ? -da : da;
                                    b_reg   <= (sgn && db[63]) ? -db : db;
                                    rem_reg <= '0;
                                    quo_reg <= '0;
                                    cnt_reg <= 7'd64;
                                    state_reg <= ST_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    acc_reg  <= acc_reg + ({64'd0, pp} <<
                                {{1'b0, step_reg[1]} + {1'b0, step_reg[0]}, 5'd0});
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3) state_reg <= ST_FIX;
                end
                ST_DIV: begin
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    if (!trial[65]) begin
                        rem_reg <= trial[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) state_reg <= ST_FIX;
                end
                ST_FIX: begin
                    if (out_free) begin
                        case (op_reg)
                            mse_pkg::OP_MULT, mse_pkg::OP_MULTU: begin
                                lo_reg <= mse_pkg::sext32(acc_reg[31:0]);
                                hi_reg <= mse_pkg::sext32(acc_reg[63:32]);
                            end
                            mse_pkg::OP_DMULT: begin
                                lo_reg <= acc_reg[63:0];
                                hi_reg <= acc_reg[127:64] - (a_reg[63] ? b_reg : 64'd0)
                                          - (b_reg[63] ? a_reg : 64'd0);
                            end
                            mse_pkg::OP_DMULTU: begin
                                lo_reg <= acc_reg[63:0];
                                hi_reg <= acc_reg[127:64];
                            end
                            mse_pkg::OP_DIV, mse_pkg::OP_DIVU: begin
                                lo_reg <= mse_pkg::sext32(qf[31:0]);
                                hi_reg <= mse_pkg::sext32(rf[31:0]);
                            end
                            default: begin
                                lo_reg <= qf;
                                hi_reg <= rf;
                            end
                        endcase
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### src/mips64_special_integer_execute.sv
// Top level of the MIPS64 special integer execute block.
// Depends on mse_pkg, mse_front, mse_queue and mse_back.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   mse_pkg::req_t
//   m_       out        m_valid / m_ready   mse_pkg::rsp_t
//
// Simple operations, traps and HI/LO moves are answered from the idle state of the back end.
// Multiplies step through ST_MUL (four 32x32 partial products in one shared multiplier) and ST_FIX.
// Divides run in ST_DIV (one quotient bit per cycle), then ST_FIX; divide by zero is answered from idle.
// Reset is synchronous; a two-word queue lets the front end run while the back end stalls.
module mips64_special_integer_execute (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mse_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mse_pkg::rsp_t m_data
);
    mse_pkg::work_t f_data, q_data;
    logic           f_valid, f_ready, q_valid, q_ready;

    mse_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .f_valid, .f_ready, .f_data
    );

    mse_queue u_queue (
        .aclk, .aresetn,
        .i_valid(f_valid), .i_ready(f_ready), .i_data(f_data),
        .o_valid(q_valid), .o_ready(q_ready), .o_data(q_data)
    );

    mse_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule

### src/mse_checker.sv
// Port-level checker for the MIPS64 special integer execute block, bound to the top level.
// Depends on mse_pkg.
module mse_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input mse_pkg::req_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input mse_pkg::rsp_t m_data
);
    a_no_write_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.dest_write |-> m_data.dest_value == 64'd0)
        else $error("Result value is not zero without a write.");

    a_exc_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.exception_code != mse_pkg::EXC_NONE |-> !m_data.dest_write)
        else $error("Exception with a register write.");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("Request word changed while stalled.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result word changed while stalled.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");
endmodule

bind mips64_special_integer_execute mse_checker u_mse_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
);

### tb/testbench.sv
// Self-checking testbench for mips64_special_integer_execute.
// Drives random and directed request words, predicts each response with a
// behavioral model of the execute unit and its HI/LO registers; uses mse_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mse_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    mse_pkg::rsp_t m_data;

    mse_pkg::req_t stim_words[$];
    mse_pkg::rsp_t expected_rsps[$];
    logic [63:0] model_hi = '0;
    logic [63:0] model_lo = '0;
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_phase = 0;

    mips64_special_integer_execute dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [63:0] sra_64(input logic [63:0] x, input int unsigned n);
        logic signed [63:0] sx;
        sx = x;
        return sx >>> n;
    endfunction

    function automatic mse_pkg::rsp_t execute_op(input mse_pkg::req_t r);
        mse_pkg::rsp_t o;
        logic [63:0] rs, rt, imm, v;
        logic [31:0] rs32, rt32, s32;
        logic signed [63:0] q, rm;
        logic [127:0] p;
        logic trap;
        rs = r.rs_value;
        rt = r.rt_value;
        rs32 = rs[31:0];
        rt32 = rt[31:0];
        imm = {{48{r.immediate[15]}}, r.immediate};
        o = '0;
        trap = 1'b0;
        v = '0;
        case (mse_pkg::op_t'(r.req_type))
            mse_pkg::OP_SLL: begin
                s32 = rt32 << r.shift_amount; v = sx32(s32); o.dest_write = 1;
            end
            mse_pkg::OP_SRL: begin
                s32 = rt32 >> r.shift_amount; v = sx32(s32); o.dest_write = 1;
            end
            mse_pkg::OP_SRA: begin
                v = sra_64(rt, r.shift_amount); v = sx32(v[31:0]); o.dest_write = 1;
            end
            mse_pkg::OP_SLLV: begin
                s32 = rt32 << rs[4:0]; v = sx32(s32); o.dest_write = 1;
            end
            mse_pkg::OP_SRLV: begin
                s32 = rt32 >> rs[4:0]; v = sx32(s32); o.dest_write = 1;
            end
            mse_pkg::OP_SRAV: begin
                v = sra_64(rt, rs[4:0]); v = sx32(v[31:0]); o.dest_write = 1;
            end
            mse_pkg::OP_DSLL:  begin v = rt << r.shift_amount; o.dest_write = 1; end
            mse_pkg::OP_DSRL:  begin v = rt >> r.shift_amount; o.dest_write = 1; end
            mse_pkg::OP_DSRA:  begin v = sra_64(rt, r.shift_amount); o.dest_write = 1; end
            mse_pkg::OP_DSLLV: begin v = rt << rs[5:0]; o.dest_write = 1; end
            mse_pkg::OP_DSRLV: begin v = rt >> rs[5:0]; o.dest_write = 1; end
            mse_pkg::OP_DSRAV: begin v = sra_64(rt, rs[5:0]); o.dest_write = 1; end
            mse_pkg::OP_DSLL32: begin v = rt << (r.shift_amount + 32); o.dest_write = 1; end
            mse_pkg::OP_DSRL32: begin v = rt >> (r.shift_amount + 32); o.dest_write = 1; end
            mse_pkg::OP_DSRA32: begin
                v = sra_64(rt, r.shift_amount + 32); o.dest_write = 1;
            end
            mse_pkg::OP_ADD, mse_pkg::OP_ADDU: begin
                s32 = rs32 + rt32;
                if (r.req_type == mse_pkg::OP_ADD &&
                    ((rs32 ^ s32) & (rt32 ^ s32) & 32'h8000_0000) != 0)
                    o.exception_code = mse_pkg::EXC_OVERFLOW;
                else begin v = sx32(s32); o.dest_write = 1; end
            end
            mse_pkg::OP_SUB, mse_pkg::OP_SUBU: begin
                s32 = rs32 - rt32;
                if (r.req_type == mse_pkg::OP_SUB &&
                    ((rs32 ^ rt32) & (rs32 ^ s32) & 32'h8000_0000) != 0)
                    o.exception_code = mse_pkg::EXC_OVERFLOW;
                else begin v = sx32(s32); o.dest_write = 1; end
            end
            mse_pkg::OP_DADD, mse_pkg::OP_DADDU: begin
                v = rs + rt;
                if (r.req_type == mse_pkg::OP_DADD && ((rs ^ v) & (rt ^ v)) >> 63 != 0) begin
                    o.exception_code = mse_pkg::EXC_OVERFLOW;
                    v = '0;
                end else o.dest_write = 1;
            end
            mse_pkg::OP_DSUB, mse_pkg::OP_DSUBU: begin
                v = rs - rt;
                if (r.req_type == mse_pkg::OP_DSUB && ((rs ^ rt) & (rs ^ v)) >> 63 != 0) begin
                    o.exception_code = mse_pkg::EXC_OVERFLOW;
                    v = '0;
                end else o.dest_write = 1;
            end
            mse_pkg::OP_MULT: begin
                p = $signed({{64{rs32[31]}}, sx32(rs32)}) *
                    $signed({{64{rt32[31]}}, sx32(rt32)});
                model_lo = sx32(p[31:0]);
                model_hi = sx32(p[63:32]);
            end
            mse_pkg::OP_MULTU: begin
                p = {96'd0, rs32} * {96'd0, rt32};
                model_lo = sx32(p[31:0]);
                model_hi = sx32(p[63:32]);
            end
            mse_pkg::OP_DIV: begin
                if (rt32 == 0) begin
                    model_lo = rs32[31] ? 64'd1 : '1;
                    model_hi = sx32(rs32);
                end else begin
                    q = $signed(sx32(rs32)) / $signed(sx32(rt32));
                    rm = $signed(sx32(rs32)) % $signed(sx32(rt32));
                    model_lo = sx32(q[31:0]);
                    model_hi = sx32(rm[31:0]);
                end
            end
            mse_pkg::OP_DIVU: begin
                if (rt32 == 0) begin
                    model_lo = '1;
                    model_hi = rs;
                end else begin
                    model_lo = sx32(rs32 / rt32);
                    model_hi = sx32(rs32 % rt32);
                end
            end
            mse_pkg::OP_DMULT: begin
                p = $signed({{64{rs[63]}}, rs}) * $signed({{64{rt[63]}}, rt});
                model_hi = p[127:64];
                model_lo = p[63:0];
            end
            mse_pkg::OP_DMULTU: begin
                p = {64'd0, rs} * {64'd0, rt};
                model_hi = p[127:64];
                model_lo = p[63:0];
            end
            mse_pkg::OP_DDIV: begin
                if (rt == 0) begin
                    model_lo = rs[63] ? 64'd1 : '1;
                    model_hi = rs;
                end else if (rs == 64'h8000_0000_0000_0000 && rt == '1) begin
                    model_lo = rs;
                    model_hi = '0;
                end else begin
                    q = $signed(rs) / $signed(rt);
                    rm = $signed(rs) % $signed(rt);
                    model_lo = q;
                    model_hi = rm;
                end
            end
            mse_pkg::OP_DDIVU: begin
                if (rt == 0) begin
                    model_lo = '1;
                    model_hi = rs;
                end else begin
                    model_lo = rs / rt;
                    model_hi = rs % rt;
                end
            end
            mse_pkg::OP_AND:   begin v = rs & rt; o.dest_write = 1; end
            mse_pkg::OP_OR:    begin v = rs | rt; o.dest_write = 1; end
            mse_pkg::OP_XOR:   begin v = rs ^ rt; o.dest_write = 1; end
            mse_pkg::OP_NOR:   begin v = ~(rs | rt); o.dest_write = 1; end
            mse_pkg::OP_TGE:   trap = $signed(rs) >= $signed(rt);
            mse_pkg::OP_TGEU:  trap = rs >= rt;
            mse_pkg::OP_TLT:   trap = $signed(rs) < $signed(rt);
            mse_pkg::OP_TLTU:  trap = rs < rt;
            mse_pkg::OP_TEQ:   trap = rs == rt;
            mse_pkg::OP_TNE:   trap = rs != rt;
            mse_pkg::OP_TGEI:  trap = $signed(rs) >= $signed(imm);
            mse_pkg::OP_TGEIU: trap = rs >= imm;
            mse_pkg::OP_TLTI:  trap = $signed(rs) < $signed(imm);
            mse_pkg::OP_TLTIU: trap = rs < imm;
            mse_pkg::OP_TEQI:  trap = rs == imm;
            mse_pkg::OP_TNEI:  trap = rs != imm;
            mse_pkg::OP_SLT: begin
                v = {63'd0, $signed(rs) < $signed(rt)}; o.dest_write = 1;
            end
            mse_pkg::OP_SLTU:  begin v = {63'd0, rs < rt}; o.dest_write = 1; end
            mse_pkg::OP_SYSCALL: o.exception_code = mse_pkg::EXC_SYSCALL;
            mse_pkg::OP_BREAK:   o.exception_code = mse_pkg::EXC_BREAK;
            mse_pkg::OP_MFHI:  begin v = model_hi; o.dest_write = 1; end
            mse_pkg::OP_MTHI:  model_hi = rs;
            mse_pkg::OP_MFLO:  begin v = model_lo; o.dest_write = 1; end
            mse_pkg::OP_MTLO:  model_lo = rs;
            default: ;
        endcase
        if (trap) o.exception_code = mse_pkg::EXC_TRAP;
        o.dest_value = o.dest_write ? v : '0;
        return o;
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '1;
            3: return 64'd0;
            4: return sx32({1'b0, 31'h7FFF_FFFF} ^ {1'($urandom_range(0, 1)), 31'd0});
            5: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom()};
            6: return 64'($urandom_range(0, 70));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic mse_pkg::req_t make_req(input logic [5:0] op, input logic [63:0] a,
                                               input logic [63:0] b);
        mse_pkg::req_t r;
        r.req_type = op;
        r.rs_value = a;
        r.rt_value = b;
        r.shift_amount = 5'($urandom());
        r.immediate = 16'($urandom());
        return r;
    endfunction

    // Sender: bursts of words separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_rsps.push_back(execute_op(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (stim_words.size() > 0) begin
                    s_data <= stim_words.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternates free-running stretches with random and long stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 900;
            if (stall_phase < 300) m_ready <= 1'b1;
            else if (stall_phase < 600) m_ready <= ($urandom_range(0, 2) != 0);
            else m_ready <= ($urandom_range(0, 7) == 0);
        end
    end

    always @(posedge aclk) begin
        mse_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response word %p", m_data);
            end else begin
                want = expected_rsps.pop_front();
                checked++;
                if (m_data.dest_write !== want.dest_write ||
                    m_data.dest_value !== want.dest_value ||
                    m_data.exception_code !== want.exception_code) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected wr=%0b val=%h exc=%0d, ",
                                  "got wr=%0b val=%h exc=%0d"},
                                 want.dest_write, want.dest_value, want.exception_code,
                                 m_data.dest_write, m_data.dest_value, m_data.exception_code);
                end
            end
        end
    end

    initial begin
        int unsigned n;
        logic [5:0] op;
        mse_pkg::req_t r;
        // Every code once, including the unused ones.
        for (int i = 0; i < 64; i++) stim_words.push_back(make_req(6'(i), pick_operand(),
                                                                   pick_operand()));
        stim_words.push_back(make_req(mse_pkg::OP_ADD, 64'h7FFF_FFFF, 64'd1));
        stim_words.push_back(make_req(mse_pkg::OP_DSUB, 64'h8000_0000_0000_0000, 64'd1));
        stim_words.push_back(make_req(mse_pkg::OP_DIV, 64'h8000_0000, '1));
        stim_words.push_back(make_req(mse_pkg::OP_MFLO, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DIV, 64'h8000_0000, 64'h1_0000_0000));
        stim_words.push_back(make_req(mse_pkg::OP_MFHI, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DIVU, 64'h1234_5678_FFFF_FFFF, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_MFHI, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DIVU, 64'hFFFF_FFFF, 64'd3));
        stim_words.push_back(make_req(mse_pkg::OP_MFLO, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DDIV, 64'h8000_0000_0000_0000, '1));
        stim_words.push_back(make_req(mse_pkg::OP_MFHI, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DDIV, '1, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_MFLO, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DDIVU, '1, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_MFLO, 64'd0, 64'd0));
        stim_words.push_back(make_req(mse_pkg::OP_DMULT, 64'h8000_0000_0000_0000, '1));
        stim_words.push_back(make_req(mse_pkg::OP_MFHI, 64'd0, 64'd0));
        n = 0;
        while (n < 570) begin
            if ($urandom_range(0, 9) < 6) begin
                // Multiply/divide or move-to, then read back HI and LO.
                if ($urandom_range(0, 4) == 0)
                    op = $urandom_range(0, 1) ? mse_pkg::OP_MTHI : mse_pkg::OP_MTLO;
                else
                    op = 6'($urandom_range(mse_pkg::OP_MULT, mse_pkg::OP_DDIVU));
                r = make_req(op, pick_operand(), pick_operand());
                if ($urandom_range(0, 7) == 0) r.rt_value = $urandom_range(0, 1) ? 64'd0 :
                                                            {$urandom(), 32'd0};
                stim_words.push_back(r);
                stim_words.push_back(make_req(mse_pkg::OP_MFHI, pick_operand(),
                                              pick_operand()));
                stim_words.push_back(make_req(mse_pkg::OP_MFLO, pick_operand(),
                                              pick_operand()));
                n += 3;
            end else begin
                r = make_req(6'($urandom()), pick_operand(), pick_operand());
                if ($urandom_range(0, 3) == 0) r.rt_value = r.rs_value;
                if (r.req_type >= mse_pkg::OP_TGEI && r.req_type <= mse_pkg::OP_TNEI &&
                    $urandom_range(0, 2) == 0)
                    r.rs_value = {{48{r.immediate[15]}}, r.immediate};
                stim_words.push_back(r);
                n++;
            end
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (stim_words.size() > 0 || s_valid || expected_rsps.size() > 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        $display("Checked %0d response words over all 64 operation codes, HI/LO sequences,",
                 checked);
        $display("overflow, trap and divide corner cases under bursty input and output stalls.");
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
src/mse_pkg.sv
src/mse_front.sv
src/mse_queue.sv
src/mse_back.sv
src/mips64_special_integer_execute.sv
src/mse_checker.sv
tb/testbench.sv
